// ===== rtl/core/ria_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Region intrusion alarm package
// Shared widths, reset values and register codes for the intrusion alarm.
// ----------------------------------------------------------------------------
package ria_pkg;

   // default parameter values
   localparam int ScaleFracBitsDef = 12;
   localparam int DetCoordBitsDef  = 10;

   // mapped frame coordinates: signed 14 bit, saturating
   localparam int MapBits = 14;
   localparam int MapMax  = 8191;
   localparam int MapMin  = -8192;

   // starting bound of the left-edge search, one bit wider than a mapped edge
   localparam int BestBits = MapBits + 1;
   localparam int InitMin  = 10000;

   // register fields
   localparam int PixBits   = 12;
   localparam int OffBits   = 10;
   localparam int ScaleBits = 16;
   localparam int CountBits = 8;
   localparam int CountMax  = 255;

   // configuration reset values
   localparam logic [PixBits-1:0]   FrameWidthRst = 12'd1920;
   localparam logic [ScaleBits-1:0] ScaleRst      = 16'd4096;
   localparam logic [CountBits-1:0] MinConsecRst  = 8'd1;

   // configuration port
   localparam int CsrAddrBits = 5;
   localparam int CsrDataBits = 32;

   typedef enum logic [2:0] {
      RegRegionLeft   = 3'd0,
      RegRegionRight  = 3'd1,
      RegFrameWidth   = 3'd2,
      RegRoiOffsetX   = 3'd3,
      RegScaleQ12     = 3'd4,
      RegOverlapThr   = 3'd5,
      RegMinConsec    = 3'd6
   } csr_index_type;

   // result word layout
   localparam int RspFieldBits = 1 + 1 + CountBits + 2 * MapBits;
   localparam int RspDataBits  = ((RspFieldBits + 7) / 8) * 8;

endpackage

// ===== rtl/core/region_intrusion_alarm.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Region intrusion alarm
// Picks one detected box per frame, classifies it against a danger region and
// raises a warning after enough consecutive touching frames.
// ----------------------------------------------------------------------------
// Path: a result word appears on rsp_tvalid once the last word of its frame
//   has passed the input register, the mapped register and the result register.
// Throughput: one box word per cycle unless a result word is held; each
//   edge has its own multiplier and the frame state updates once per word.
// Reset: synchronous, active high; clears the pipeline, the frame state and
//   the hit counter, and loads the register defaults.
module region_intrusion_alarm #(
   parameter int ScaleFracBits = ria_pkg::ScaleFracBitsDef,
   parameter int DetCoordBits  = ria_pkg::DetCoordBitsDef
) (
   input  logic                              clock,
   input  logic                              reset,
   // box words
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // box_left, box_right, zero padding
   input  logic [((2*DetCoordBits+7)/8)*8-1:0] req_tdata,
   input  logic                              req_tlast,   // last_in_frame
   input  logic                              req_tuser,   // no_box
   // result words
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // warning, touched_now, hit_count_out, chosen_left, chosen_right, padding
   output logic [ria_pkg::RspDataBits-1:0]   rsp_tdata,
   // configuration port
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [ria_pkg::CsrAddrBits-1:0]   csr_paddr,
   input  logic [ria_pkg::CsrDataBits-1:0]   csr_pwdata,
   output logic [ria_pkg::CsrDataBits-1:0]   csr_prdata,
   output logic                              csr_pready
);

   localparam int Cw  = DetCoordBits;
   localparam int Mw  = ria_pkg::MapBits;
   localparam int Bw  = ria_pkg::BestBits;
   localparam int Pw  = Cw + 1 + ria_pkg::ScaleBits + 1;   // product width
   localparam int RspPad      = ria_pkg::RspDataBits - ria_pkg::RspFieldBits;

   localparam logic signed [Pw-1:0] SatHi = Pw'(ria_pkg::MapMax);
   localparam logic signed [Pw-1:0] SatLo = Pw'(ria_pkg::MapMin);

   // -------------------------------------------------------------------------
   // Configuration registers
   // -------------------------------------------------------------------------
   logic [ria_pkg::PixBits-1:0]   region_left_ff,  region_right_ff, frame_width_ff;
   logic [ria_pkg::OffBits-1:0]   roi_offset_ff;
   logic [ria_pkg::ScaleBits-1:0] scale_ff;
   logic [ria_pkg::PixBits-1:0]   overlap_thr_ff;
   logic [ria_pkg::CountBits-1:0] min_consec_ff;

   logic                    csr_write;
   ria_pkg::csr_index_type  csr_index;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_index  = ria_pkg::csr_index_type'(csr_paddr[4:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         region_left_ff  <= '0;
         region_right_ff <= '0;
         frame_width_ff  <= ria_pkg::FrameWidthRst;
         roi_offset_ff   <= '0;
         scale_ff        <= ria_pkg::ScaleRst;
         overlap_thr_ff  <= '0;
         min_consec_ff   <= ria_pkg::MinConsecRst;
      end else if (csr_write) begin
         unique case (csr_index)
            ria_pkg::RegRegionLeft:  region_left_ff  <= csr_pwdata[ria_pkg::PixBits-1:0];
            ria_pkg::RegRegionRight: region_right_ff <= csr_pwdata[ria_pkg::PixBits-1:0];
            ria_pkg::RegFrameWidth:  frame_width_ff  <= csr_pwdata[ria_pkg::PixBits-1:0];
            ria_pkg::RegRoiOffsetX:  roi_offset_ff   <= csr_pwdata[ria_pkg::OffBits-1:0];
            ria_pkg::RegScaleQ12:    scale_ff        <= csr_pwdata[ria_pkg::ScaleBits-1:0];
            ria_pkg::RegOverlapThr:  overlap_thr_ff  <= csr_pwdata[ria_pkg::PixBits-1:0];
            ria_pkg::RegMinConsec:   min_consec_ff   <= csr_pwdata[ria_pkg::CountBits-1:0];
            default: ;   // unmapped address: drop the write
         endcase
      end
   end

   // read back, zero above each field
   always_comb begin
      unique case (csr_index)
         ria_pkg::RegRegionLeft:  csr_prdata = ria_pkg::CsrDataBits'(region_left_ff);
         ria_pkg::RegRegionRight: csr_prdata = ria_pkg::CsrDataBits'(region_right_ff);
         ria_pkg::RegFrameWidth:  csr_prdata = ria_pkg::CsrDataBits'(frame_width_ff);
         ria_pkg::RegRoiOffsetX:  csr_prdata = ria_pkg::CsrDataBits'(roi_offset_ff);
         ria_pkg::RegScaleQ12:    csr_prdata = ria_pkg::CsrDataBits'(scale_ff);
         ria_pkg::RegOverlapThr:  csr_prdata = ria_pkg::CsrDataBits'(overlap_thr_ff);
         ria_pkg::RegMinConsec:   csr_prdata = ria_pkg::CsrDataBits'(min_consec_ff);
         default:                 csr_prdata = '0;
      endcase
   end

   // -------------------------------------------------------------------------
   // Flow control: each stage moves when the one after it has room, so a
   // waiting result word blocks only a closing word and the words behind it.
   // -------------------------------------------------------------------------
   logic s1_valid_ff, s1_valid_in;
   logic s2_valid_ff, s2_valid_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic s2_last_ff, s2_none_ff;

   logic req_accept, s1_move, s2_fire, s2_free, out_free;

   assign out_free   = ~rsp_valid_ff | rsp_tready;
   assign s2_fire    = s2_valid_ff & (~s2_last_ff | out_free);
   assign s2_free    = ~s2_valid_ff | s2_fire;
   assign s1_move    = s1_valid_ff & s2_free;
   assign req_tready = ~s1_valid_ff | s2_free;
   assign req_accept = req_tvalid & req_tready;

   always_comb begin
      s1_valid_in  = req_accept ? 1'b1 : (s1_move ? 1'b0 : s1_valid_ff);
      s2_valid_in  = s1_move ? 1'b1 : (s2_fire ? 1'b0 : s2_valid_ff);
      rsp_valid_in = (s2_fire & s2_last_ff) ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
   end

   // -------------------------------------------------------------------------
   // Stage 1: input register
   // -------------------------------------------------------------------------
   logic [Cw-1:0] s1_left_ff, s1_right_ff;
   logic          s1_last_ff, s1_none_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      if (req_accept) begin
         s1_left_ff  <= req_tdata[Cw-1:0];
         s1_right_ff <= req_tdata[2*Cw-1:Cw];
         s1_last_ff  <= req_tlast;
         s1_none_ff  <= req_tuser;
      end
   end

   // -------------------------------------------------------------------------
   // Edge mapping: (x - offset) * scale, floored by an arithmetic shift,
   // then saturated to the signed mapped range.
   // -------------------------------------------------------------------------
   logic [Cw+ria_pkg::OffBits-1:0] off_pad;
   logic [Cw-1:0]                  off_w;
   logic signed [Mw-1:0]           map_left, map_right;

   assign off_pad = {{Cw{1'b0}}, roi_offset_ff};
   assign off_w   = off_pad[Cw-1:0];

   function automatic logic signed [Mw-1:0] map_edge(
      input logic [Cw-1:0]                  x,
      input logic [Cw-1:0]                  off,
      input logic [ria_pkg::ScaleBits-1:0]  scale
   );
      logic signed [Cw:0]                     diff;
      logic signed [ria_pkg::ScaleBits:0]     sc;
      logic signed [Pw-1:0]                   prod;
      logic signed [Pw-1:0]                   quo;
      logic signed [Mw-1:0]                   res;
      diff = $signed({1'b0, x}) - $signed({1'b0, off});
      sc   = $signed({1'b0, scale});
      prod = diff * sc;
      quo  = prod >>> ScaleFracBits;
      if (quo > SatHi) begin
         res = Mw'(ria_pkg::MapMax);
      end else if (quo < SatLo) begin
         res = Mw'(ria_pkg::MapMin);
      end else begin
         res = quo[Mw-1:0];
      end
      return res;
   endfunction

   assign map_left  = map_edge(s1_left_ff, off_w, scale_ff);
   assign map_right = map_edge(s1_right_ff, off_w, scale_ff);

   // -------------------------------------------------------------------------
   // Stage 2: mapped edges
   // -------------------------------------------------------------------------
   logic signed [Mw-1:0] s2_left_ff, s2_right_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s2_valid_in;
      end
      if (s1_move) begin
         s2_left_ff  <= map_left;
         s2_right_ff <= map_right;
         s2_last_ff  <= s1_last_ff;
         s2_none_ff  <= s1_none_ff;
      end
   end

   // -------------------------------------------------------------------------
   // Box selection and frame close
   // -------------------------------------------------------------------------
   logic                           first_seen_ff, first_seen_in;
   logic signed [Bw-1:0]           best_min_ff, best_min_in;
   logic signed [Mw-1:0]           best_max_ff, best_max_in;
   logic signed [Mw-1:0]           sel_left_ff, sel_left_in;
   logic signed [Mw-1:0]           sel_right_ff, sel_right_in;
   logic [ria_pkg::CountBits-1:0]  hit_count_ff, hit_count_in;

   logic [ria_pkg::PixBits:0]      region_sum;
   logic                           left_side;

   // region centre against frame centre
   assign region_sum = {1'b0, region_left_ff} + {1'b0, region_right_ff};
   assign left_side  = region_sum[ria_pkg::PixBits:1] <= (frame_width_ff >> 1);

   // frame state after this word's box, before any close
   logic                 seen_box;
   logic signed [Mw-1:0] cur_left, cur_right;

   always_comb begin
      seen_box    = first_seen_ff;
      best_min_in = best_min_ff;
      best_max_in = best_max_ff;
      cur_left    = sel_left_ff;
      cur_right   = sel_right_ff;
      if (!s2_none_ff) begin
         if (!first_seen_ff) begin
            cur_left  = s2_left_ff;
            cur_right = s2_right_ff;
         end
         seen_box = 1'b1;
         if (left_side) begin
            if (Bw'(s2_left_ff) < best_min_ff) begin
               best_min_in = Bw'(s2_left_ff);
               cur_left    = s2_left_ff;
               cur_right   = s2_right_ff;
            end
         end else begin
            if (s2_right_ff > best_max_ff) begin
               best_max_in = s2_right_ff;
               cur_left    = s2_left_ff;
               cur_right   = s2_right_ff;
            end
         end
      end
   end

   // classify the kept box; first matching rule decides
   logic signed [Bw-1:0] cl_bl, cl_br, cl_l, cl_r, cl_t;
   logic                 overlaps;
   logic                 touch;

   assign cl_bl = Bw'(cur_left);
   assign cl_br = Bw'(cur_right);
   assign cl_l  = $signed({{(Bw-ria_pkg::PixBits){1'b0}}, region_left_ff});
   assign cl_r  = $signed({{(Bw-ria_pkg::PixBits){1'b0}}, region_right_ff});
   assign cl_t  = $signed({{(Bw-ria_pkg::PixBits){1'b0}}, overlap_thr_ff});

   always_comb begin
      priority if (cl_br < cl_l || cl_bl > cl_r) begin
         overlaps = 1'b0;                               // outside
      end else if (cl_br > cl_l && cl_br < cl_r) begin
         overlaps = (cl_br - cl_l) >= cl_t;             // partial on the right
      end else if (cl_bl > cl_l && cl_bl < cl_r) begin
         overlaps = (cl_r - cl_bl) >= cl_t;             // partial on the left
      end else if (cl_bl < cl_l && cl_br > cl_r) begin
         overlaps = 1'b1;                               // box covers region
      end else if (cl_bl > cl_l && cl_br < cl_r) begin
         overlaps = 1'b1;                               // region contains box
      end else begin
         overlaps = 1'b0;
      end
   end

   // an empty frame never touches
   assign touch = seen_box & overlaps;

   always_comb begin
      if (touch) begin
         hit_count_in = (hit_count_ff == ria_pkg::CountBits'(ria_pkg::CountMax)) ?
                        hit_count_ff : hit_count_ff + 1'b1;
      end else begin
         hit_count_in = '0;
      end
   end

   // close the frame on its last word: back to the starting bounds
   always_comb begin
      if (s2_last_ff) begin
         first_seen_in = 1'b0;
         sel_left_in   = '0;
         sel_right_in  = '0;
      end else begin
         first_seen_in = seen_box;
         sel_left_in   = cur_left;
         sel_right_in  = cur_right;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_seen_ff <= 1'b0;
         best_min_ff   <= Bw'(ria_pkg::InitMin);
         best_max_ff   <= '0;
         sel_left_ff   <= '0;
         sel_right_ff  <= '0;
         hit_count_ff  <= '0;
      end else if (s2_fire) begin
         first_seen_ff <= first_seen_in;
         sel_left_ff   <= sel_left_in;
         sel_right_ff  <= sel_right_in;
         if (s2_last_ff) begin
            best_min_ff  <= Bw'(ria_pkg::InitMin);
            best_max_ff  <= '0;
            hit_count_ff <= hit_count_in;
         end else begin
            best_min_ff  <= best_min_in;
            best_max_ff  <= best_max_in;
         end
      end
   end

   // -------------------------------------------------------------------------
   // Result register
   // -------------------------------------------------------------------------
   logic                           rsp_warn_ff, rsp_touch_ff;
   logic [ria_pkg::CountBits-1:0]  rsp_count_ff;
   logic signed [Mw-1:0]           rsp_left_ff, rsp_right_ff;
   logic                           warn_in;

   assign warn_in = touch & (hit_count_in >= min_consec_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (s2_fire && s2_last_ff) begin
         rsp_warn_ff  <= warn_in;
         rsp_touch_ff <= touch;
         rsp_count_ff <= hit_count_in;
         // kept edges are still zero when the frame had no box
         rsp_left_ff  <= cur_left;
         rsp_right_ff <= cur_right;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{RspPad{1'b0}}, rsp_right_ff, rsp_left_ff, rsp_count_ff,
                        rsp_touch_ff, rsp_warn_ff};

   // -------------------------------------------------------------------------
   // Assertions
   // -------------------------------------------------------------------------
   // a warning is only raised on a touching frame
   a_warn_needs_touch: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (!rsp_warn_ff || rsp_touch_ff))
      else $error("warning without touch");

   // the hit count is nonzero exactly on touching frames
   a_count_matches_touch: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_touch_ff == (rsp_count_ff != '0)))
      else $error("hit count disagrees with touch");

   // a closed frame leaves the frame state at its starting values
   a_frame_cleared: assert property (@(posedge clock) disable iff (reset)
      (s2_fire && s2_last_ff) |=> (!first_seen_ff && best_max_ff == '0
                                    && best_min_ff == Bw'(ria_pkg::InitMin)))
      else $error("frame state not cleared after last word");

   // a word that closes a frame always produces a result word
   a_last_gives_result: assert property (@(posedge clock) disable iff (reset)
      (s2_fire && s2_last_ff) |=> rsp_valid_ff)
      else $error("closing word gave no result");

endmodule
